[rtl/id3x_pkg.sv]
// Package: payload types and constants for the ID3 tag field extractor.
package id3x_pkg;

	localparam int FieldBytes   = 64;
	localparam int HeadBytes    = 4096;
	localparam int TrailerBytes = 128;

	localparam logic [7:0] VerNone = 8'hFF;
	localparam logic [7:0] VerV1   = 8'h11;

	typedef struct packed {
		logic       kind;
		logic       first;
		logic       last;
		logic [7:0] data;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  field;
		logic [5:0]  position;
		logic [7:0]  value;
		logic [7:0]  version;
		logic [27:0] tag_size;
		logic [6:0]  title_len;
		logic [6:0]  artist_len;
		logic [6:0]  album_len;
		logic [15:0] genre;
		logic        found;
		logic        final_res;
	} out_word_t;

	// Text byte produced by one step of the parser
	typedef struct packed {
		logic       vld;
		logic [1:0] field;
		logic [5:0] position;
		logic [7:0] value;
	} text_t;

	// Per-step summary snapshot
	typedef struct packed {
		logic        vld;
		logic [7:0]  version;
		logic [27:0] tag_size;
		logic [6:0]  title_len;
		logic [6:0]  artist_len;
		logic [6:0]  album_len;
		logic [15:0] genre;
	} summ_t;

endpackage

[rtl/id3x_parse.sv]
// Parser: per-byte state update, text byte and summary snapshot of one stage.
module id3x_parse import id3x_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_word_t in_w,
	output text_t    txt,
	output summ_t    summ
);

	logic [3:0]  stage_q;
	logic [1:0]  fkind_q;
	logic [12:0] off_q;
	logic [6:0]  sub_q;
	logic [31:0] acc_q [4];
	logic [2:0]  frames_q;
	logic [27:0] hsize_q;
	logic [7:0]  ver_q;
	logic [7:0]  gdig_q [4];
	logic [15:0] gnum_q;
	logic [6:0]  len_q [3];
	logic        v2_q;
	logic        bkind_q;

	logic [3:0]  stage_d;
	logic [1:0]  fkind_d;
	logic [12:0] off_d;
	logic [6:0]  sub_d;
	logic [31:0] acc_d [4];
	logic [2:0]  frames_d;
	logic [27:0] hsize_d;
	logic [7:0]  ver_d;
	logic [7:0]  gdig_d [4];
	logic [15:0] gnum_d;
	logic [6:0]  len_d [3];
	logic        v2_d;
	logic        bkind_d;

	logic [7:0]  d;
	logic [1:0]  f;
	logic [31:0] acc_sel;
	logic [31:0] acc_add;
	logic [6:0]  sub_inc;
	logic [27:0] limit;
	logic [6:0]  v1_pos;
	logic [1:0]  v1_fld;
	logic [15:0] gsum;
	logic [2:0]  gk;

	assign d = in_w.data;

	always_comb begin
		stage_d  = stage_q;
		fkind_d  = fkind_q;
		off_d    = off_q;
		sub_d    = sub_q;
		acc_d    = acc_q;
		frames_d = frames_q;
		hsize_d  = hsize_q;
		ver_d    = ver_q;
		gdig_d   = gdig_q;
		gnum_d   = gnum_q;
		len_d    = len_q;
		v2_d     = v2_q;
		bkind_d  = bkind_q;
		txt      = '0;
		f        = '0;
		acc_sel  = '0;
		acc_add  = '0;
		sub_inc  = '0;
		limit    = '0;
		v1_pos   = '0;
		v1_fld   = '0;
		gsum     = '0;
		gk       = '0;

		if (in_w.first) begin
			stage_d  = '0;
			fkind_d  = '0;
			off_d    = '0;
			sub_d    = '0;
			for (int i = 0; i < 4; i++) begin
				acc_d[i]  = '0;
				gdig_d[i] = '0;
			end
			for (int i = 0; i < 3; i++) len_d[i] = '0;
			frames_d = '0;
			hsize_d  = '0;
			ver_d    = VerNone;
			v2_d     = 1'b0;
			bkind_d  = in_w.kind;
		end

		if (bkind_d) begin
			if (off_d < 13'(TrailerBytes)) begin
				unique case (stage_d)
					4'd0: if (d == "T") stage_d = 4'd1;
					4'd1: stage_d = (d == "A") ? 4'd2 : 4'd0;
					4'd2: begin
						if (d == "G") begin
							stage_d = 4'd3;
							ver_d   = VerV1;
							sub_d   = '0;
						end else begin
							stage_d = 4'd0;
						end
					end
					4'd3: begin
						if (sub_d >= 7'd60) begin
							v1_fld = 2'd2;
							v1_pos = sub_d - 7'd60;
						end else if (sub_d >= 7'd30) begin
							v1_fld = 2'd1;
							v1_pos = sub_d - 7'd30;
						end else begin
							v1_fld = 2'd0;
							v1_pos = sub_d;
						end
						txt = '{vld: 1'b1, field: v1_fld, position: v1_pos[5:0], value: d};
						sub_d = sub_d + 7'd1;
						if (sub_d == 7'd90) begin
							for (int i = 0; i < 3; i++) len_d[i] = 7'd30;
							stage_d = 4'd4;
							sub_d   = '0;
						end
					end
					4'd4: begin
						sub_d = sub_d + 7'd1;
						if (sub_d == 7'd34) begin
							stage_d = 4'd5;
							sub_d   = '0;
						end
					end
					4'd5: begin
						gnum_d  = {8'd0, d};
						stage_d = 4'd6;
					end
					default: ;
				endcase
			end
		end else begin
			limit = (hsize_d < 28'(HeadBytes)) ? hsize_d : 28'(HeadBytes);
			if (off_d == 13'd0) v2_d = (d == "I");
			else if (off_d == 13'd1) v2_d = v2_d && (d == "D");
			else if (off_d == 13'd2) v2_d = v2_d && (d == "3");
			else if (off_d == 13'd3) begin
				if (v2_d) ver_d = d;
			end else if (off_d >= 13'd6 && off_d <= 13'd9) begin
				if (v2_d) hsize_d = {hsize_d[20:0], d[6:0]};
			end else if (off_d >= 13'd10 && v2_d && frames_d < 3'd4
					&& 28'(off_d) < limit) begin
				unique case (stage_d)
					4'd0: if (d == "T") stage_d = 4'd1;
					4'd1: begin
						if (d == "P") begin
							stage_d = 4'd2;
							fkind_d = 2'd1;
						end else if (d == "I") begin
							stage_d = 4'd2;
							fkind_d = 2'd0;
						end else if (d == "A") begin
							stage_d = 4'd2;
							fkind_d = 2'd2;
						end else if (d == "C") begin
							stage_d = 4'd6;
						end else begin
							stage_d = 4'd0;
						end
					end
					4'd2: begin
						if (fkind_d == 2'd1) stage_d = (d == "E") ? 4'd3 : 4'd0;
						else if (fkind_d == 2'd0) stage_d = (d == "T") ? 4'd3 : 4'd0;
						else stage_d = (d == "L") ? 4'd3 : 4'd0;
					end
					4'd3: begin
						if (fkind_d == 2'd1)
							stage_d = (d > 8'h30 && d < 8'h35) ? 4'd4 : 4'd0;
						else if (fkind_d == 2'd0)
							stage_d = (d > 8'h30 && d < 8'h34) ? 4'd4 : 4'd0;
						else
							stage_d = (d == "B") ? 4'd4 : 4'd0;
						sub_d = '0;
					end
					4'd4, 4'd8: begin
						f       = (stage_d == 4'd4) ? fkind_d : 2'd3;
						acc_sel = acc_d[f];
						unique case (sub_d[1:0])
							2'd0:    acc_add = {d, 24'd0};
							2'd1:    acc_add = {8'd0, d, 16'd0};
							2'd2:    acc_add = {16'd0, d, 8'd0};
							default: acc_add = {24'd0, d};
						endcase
						if (sub_d < 7'd4) acc_sel = acc_sel + acc_add;
						sub_inc = sub_d + 7'd1;
						if (sub_inc == 7'd7) begin
							sub_d = '0;
							if (!acc_sel[31] && acc_sel > 32'd1) begin
								acc_sel = acc_sel - 32'd1;
								if (acc_sel > 32'(FieldBytes)) acc_sel = 32'(FieldBytes - 1);
								stage_d = stage_d + 4'd1;
							end else begin
								stage_d = 4'd0;
							end
						end else begin
							sub_d = sub_inc;
						end
						acc_d[f] = acc_sel;
					end
					4'd5, 4'd9: begin
						f       = (stage_d == 4'd5) ? fkind_d : 2'd3;
						acc_sel = acc_d[f];
						txt = '{vld: 1'b1, field: f, position: sub_d[5:0], value: d};
						if (f == 2'd3 && sub_d < 7'd4) gdig_d[sub_d[1:0]] = d;
						sub_d = sub_d + 7'd1;
						if (acc_sel == 32'(sub_d)) begin
							frames_d = frames_d + 3'd1;
							if (f != 2'd3) begin
								len_d[f] = acc_sel[6:0];
							end else if (acc_sel > 32'd2 && acc_sel < 32'd6) begin
								gk       = 3'(acc_sel - 32'd2);
								acc_d[3] = 32'(gk);
								// digits 1..k, index 1 being the most significant digit
								gsum = 16'(gdig_d[1]) - 16'd48;
								if (gk >= 3'd2)
									gsum = 16'(gsum * 16'd10) + 16'(gdig_d[2]) - 16'd48;
								if (gk >= 3'd3)
									gsum = 16'(gsum * 16'd10) + 16'(gdig_d[3]) - 16'd48;
								gnum_d = gsum;
							end
							if (frames_d != 3'd4) begin
								stage_d = 4'd0;
								sub_d   = '0;
							end
						end
					end
					4'd6: stage_d = (d == "O") ? 4'd7 : 4'd0;
					4'd7: begin
						stage_d = (d == "N") ? 4'd8 : 4'd0;
						sub_d   = '0;
					end
					default: ;
				endcase
			end
		end

		if (off_d < 13'(HeadBytes)) off_d = off_d + 13'd1;

		summ.vld        = in_w.last;
		summ.version    = ver_d;
		summ.tag_size   = hsize_d;
		summ.title_len  = len_d[0];
		summ.artist_len = len_d[1];
		summ.album_len  = len_d[2];
		summ.genre      = gnum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= '0;
			fkind_q  <= '0;
			off_q    <= '0;
			sub_q    <= '0;
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			for (int i = 0; i < 3; i++) len_q[i] <= '0;
			frames_q <= '0;
			hsize_q  <= '0;
			ver_q    <= VerNone;
			gnum_q   <= '0;
			v2_q     <= 1'b0;
			bkind_q  <= 1'b0;
		end else if (step) begin
			stage_q  <= stage_d;
			fkind_q  <= fkind_d;
			off_q    <= off_d;
			sub_q    <= sub_d;
			acc_q    <= acc_d;
			len_q    <= len_d;
			frames_q <= frames_d;
			hsize_q  <= hsize_d;
			ver_q    <= ver_d;
			gnum_q   <= gnum_d;
			v2_q     <= v2_d;
			bkind_q  <= bkind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) gdig_q <= gdig_d;
	end

endmodule

[rtl/id3x_emit.sv]
// Output stage: holds up to two result words and hands them out in order.
module id3x_emit import id3x_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  text_t     txt,
	input  summ_t     summ,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_w
);

	text_t       txt_s1;
	summ_t       summ_s1;
	logic        txt_pend_q;
	logic        summ_pend_q;
	logic        pop;

	assign out_valid = txt_pend_q || summ_pend_q;
	assign pop       = out_valid && out_ready;
	// accept a new step when the held words all leave this cycle
	assign room = !out_valid || (out_ready && !(txt_pend_q && summ_pend_q));

	always_comb begin
		out_w = '0;
		if (txt_pend_q) begin
			out_w.field     = txt_s1.field;
			out_w.position  = txt_s1.position;
			out_w.value     = txt_s1.value;
			out_w.final_res = !summ_pend_q;
		end else begin
			out_w.result_kind = 1'b1;
			out_w.version     = summ_s1.version;
			out_w.tag_size    = summ_s1.tag_size;
			out_w.title_len   = summ_s1.title_len;
			out_w.artist_len  = summ_s1.artist_len;
			out_w.album_len   = summ_s1.album_len;
			out_w.genre       = summ_s1.genre;
			out_w.found       = (summ_s1.artist_len != '0) || (summ_s1.album_len != '0);
			out_w.final_res   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_pend_q  <= 1'b0;
			summ_pend_q <= 1'b0;
		end else if (load) begin
			txt_pend_q  <= txt.vld;
			summ_pend_q <= summ.vld;
		end else if (pop) begin
			if (txt_pend_q) txt_pend_q <= 1'b0;
			else summ_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			txt_s1  <= txt;
			summ_s1 <= summ;
		end
	end

endmodule

[rtl/id3x_top.sv]
// Top level of the ID3 tag field extractor.
// A word's first result word is registered and offered in the cycle after the word is accepted.
// Throughput: one word per cycle while it yields at most one result and the
// sink keeps up; a word with a text byte and a summary holds the input until
// its text word has left the output register.
// Reset: arst_n clears parse state to head-buffer scan at offset zero.
module id3_tag_field_extractor_top import id3x_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	text_t txt;
	summ_t summ;
	logic  step;

	assign step = in_valid && in_ready;

	id3x_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.in_w   (in_data),
		.txt    (txt),
		.summ   (summ)
	);

	id3x_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.txt       (txt),
		.summ      (summ),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_w     (out_data)
	);

endmodule

[bench/tb_top.sv]
// Testbench for the ID3 tag field extractor: predicts every result word and checks it
`timescale 1ns / 1ps

module tb_top;
	import id3x_pkg::*;

	// parse stages of the v2 frame scan
	localparam int S_SEEK = 0, S_T = 1, S_TX = 2, S_NUM = 3, S_SIZE = 4, S_TEXT = 5;
	localparam int S_CO = 6, S_CON = 7, S_GSIZE = 8, S_GTEXT = 9;
	// parse stages of the v1 trailer scan
	localparam int V1_SEEK = 0, V1_A = 1, V1_G = 2, V1_TEXT = 3, V1_SKIP = 4;
	localparam int V1_GENRE = 5, V1_DONE = 6;
	localparam int F_TITLE = 0, F_ARTIST = 1, F_ALBUM = 2, F_GENRE = 3;
	localparam logic RK_TEXT = 1'b0, RK_SUMM = 1'b1;
	localparam logic KIND_HEAD = 1'b0, KIND_TRAILER = 1'b1;
	localparam int STALL_LIMIT = 4000;

	logic      clk, arst_n;
	logic      in_valid, in_ready, out_valid, out_ready;
	in_word_t  in_data;
	out_word_t out_data;

	id3_tag_field_extractor_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	in_word_t  pending_words[$];
	out_word_t expected_results[$];
	int n_err, n_words, n_results, n_buffers, idle_phase, quiet_cycles;
	logic word_taken;

	// tag parser shadow state
	int          stage, fkind, boff, sub, frames;
	logic [31:0] acc[4];
	logic [27:0] hsize;
	logic [7:0]  ver, digits[4];
	logic [15:0] gnum;
	logic [6:0]  slen[3];
	logic        isv2, bkind;

	function automatic void clear_buffer();
		stage = S_SEEK; fkind = 0; boff = 0; sub = 0; frames = 0;
		foreach (acc[i]) acc[i] = '0;
		foreach (digits[i]) digits[i] = '0;
		foreach (slen[i]) slen[i] = '0;
		hsize = '0; ver = VerNone; isv2 = 1'b0;
	endfunction

	function automatic out_word_t text_word(int f, int pos, logic [7:0] v);
		out_word_t t;
		t = '0;
		t.result_kind = RK_TEXT;
		t.field = f[1:0];
		t.position = pos[5:0];
		t.value = v;
		return t;
	endfunction

	task automatic frame_byte(logic [7:0] d, ref out_word_t r[$]);
		int f, k;
		logic [31:0] num;
		logic ok;
		case (stage)
			S_SEEK: if (d == "T") stage = S_T;
			S_T: begin
				if (d == "P") begin stage = S_TX; fkind = F_ARTIST; end
				else if (d == "I") begin stage = S_TX; fkind = F_TITLE; end
				else if (d == "A") begin stage = S_TX; fkind = F_ALBUM; end
				else if (d == "C") stage = S_CO;
				else stage = S_SEEK;
			end
			S_TX: begin
				if (fkind == F_ARTIST) ok = d == "E";
				else if (fkind == F_TITLE) ok = d == "T";
				else ok = d == "L";
				stage = ok ? S_NUM : S_SEEK;
			end
			S_NUM: begin
				if (fkind == F_ARTIST) ok = d > 8'h30 && d < 8'h35;
				else if (fkind == F_TITLE) ok = d > 8'h30 && d < 8'h34;
				else ok = d == "B";
				stage = ok ? S_SIZE : S_SEEK;
				sub = 0;
			end
			S_SIZE, S_GSIZE: begin
				f = (stage == S_SIZE) ? fkind : F_GENRE;
				if (sub < 4) acc[f] += 32'(d) << (24 - 8 * sub);
				sub++;
				if (sub == 7) begin
					sub = 0;
					if (!acc[f][31] && acc[f] > 1) begin
						acc[f] -= 1;
						if (acc[f] > FieldBytes) acc[f] = FieldBytes - 1;
						stage = stage + 1;
					end else begin
						stage = S_SEEK;
					end
				end
			end
			S_TEXT, S_GTEXT: begin
				f = (stage == S_TEXT) ? fkind : F_GENRE;
				r.push_back(text_word(f, sub, d));
				if (f == F_GENRE && sub < 4) digits[sub] = d;
				sub++;
				if (acc[f] == sub) begin
					frames++;
					if (f != F_GENRE) begin
						slen[f] = acc[f][6:0];
					end else if (acc[f] > 2 && acc[f] < 6) begin
						k = acc[f] - 2;
						acc[f] = k;
						num = '0;
						for (int i = 1; i <= k; i++) num = num * 10 + (32'(digits[i]) - 48);
						gnum = num[15:0];
					end
					if (frames != 4) begin stage = S_SEEK; sub = 0; end
				end
			end
			S_CO: stage = (d == "O") ? S_CON : S_SEEK;
			S_CON: begin
				stage = (d == "N") ? S_GSIZE : S_SEEK;
				sub = 0;
			end
			default: ;
		endcase
	endtask

	task automatic head_byte(logic [7:0] d, ref out_word_t r[$]);
		int limit;
		if (boff == 0) isv2 = d == "I";
		else if (boff == 1) isv2 = isv2 && d == "D";
		else if (boff == 2) isv2 = isv2 && d == "3";
		else if (boff == 3) begin if (isv2) ver = d; end
		else if (boff >= 6 && boff <= 9) begin
			if (isv2) hsize = {hsize[20:0], d[6:0]};
		end else if (boff >= 10 && isv2 && frames < 4) begin
			limit = (hsize < HeadBytes) ? int'(hsize) : HeadBytes;
			if (boff < limit) frame_byte(d, r);
		end
	endtask

	task automatic trailer_byte(logic [7:0] d, ref out_word_t r[$]);
		if (boff >= TrailerBytes) return;
		case (stage)
			V1_SEEK: if (d == "T") stage = V1_A;
			V1_A: stage = (d == "A") ? V1_G : V1_SEEK;
			V1_G: begin
				if (d == "G") begin stage = V1_TEXT; ver = VerV1; sub = 0; end
				else stage = V1_SEEK;
			end
			V1_TEXT: begin
				r.push_back(text_word(sub / 30, sub % 30, d));
				sub++;
				if (sub == 90) begin
					foreach (slen[i]) slen[i] = 7'd30;
					stage = V1_SKIP; sub = 0;
				end
			end
			V1_SKIP: begin
				sub++;
				if (sub == 34) begin stage = V1_GENRE; sub = 0; end
			end
			V1_GENRE: begin
				gnum = {8'h00, d};
				stage = V1_DONE;
			end
			default: ;
		endcase
	endtask

	task automatic predict_results(in_word_t w);
		out_word_t r[$];
		out_word_t s;
		if (w.first) begin
			clear_buffer();
			bkind = w.kind;
		end
		if (bkind == KIND_TRAILER) trailer_byte(w.data, r);
		else head_byte(w.data, r);
		if (boff < HeadBytes) boff++;
		if (w.last) begin
			s = '0;
			s.result_kind = RK_SUMM;
			s.version = ver;
			s.tag_size = hsize;
			s.title_len = slen[0];
			s.artist_len = slen[1];
			s.album_len = slen[2];
			s.genre = gnum;
			s.found = slen[1] != 0 || slen[2] != 0;
			r.push_back(s);
		end
		if (r.size() > 0) r[r.size() - 1].final_res = 1'b1;
		foreach (r[i]) expected_results.push_back(r[i]);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endtask

	task automatic check_result(out_word_t got);
		out_word_t want;
		if (expected_results.size() == 0) begin
			$error("result word with nothing expected: %h", got);
			n_err++;
			return;
		end
		want = expected_results.pop_front();
		check_field("result_kind", want.result_kind, got.result_kind);
		check_field("field", want.field, got.field);
		check_field("position", want.position, got.position);
		check_field("value", want.value, got.value);
		check_field("version", want.version, got.version);
		check_field("tag_size", want.tag_size, got.tag_size);
		check_field("title_len", want.title_len, got.title_len);
		check_field("artist_len", want.artist_len, got.artist_len);
		check_field("album_len", want.album_len, got.album_len);
		check_field("genre", $signed(want.genre), $signed(got.genre));
		check_field("found", want.found, got.found);
		check_field("final_res", want.final_res, got.final_res);
	endtask

	// sample both channels and run the shadow parser
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_results(in_data);
				word_taken <= 1'b1;
				n_words++;
			end
			if (out_valid && out_ready) begin
				check_result(out_data);
				n_results++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(pending_words.size() == 0 && !in_valid && expected_results.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no progress for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// drive the input and the sink at the falling edge
	always @(negedge clk) begin
		int sidle, ridle;
		sidle = (idle_phase == 0) ? 13 : (idle_phase == 1) ? 64 : 0;
		ridle = (idle_phase == 0) ? 64 : (idle_phase == 1) ? 13 : 0;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || word_taken) begin
				if (pending_words.size() == 0 || $urandom_range(99) < sidle) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end
			end
			out_ready <= $urandom_range(99) >= ridle;
			word_taken <= 1'b0;
		end
	end

	task automatic queue_buffer(logic kind, logic [7:0] b[$]);
		in_word_t w;
		foreach (b[i]) begin
			w.kind = kind;
			w.first = i == 0;
			w.last = i == b.size() - 1;
			w.data = b[i];
			pending_words.push_back(w);
		end
		n_buffers++;
	endtask

	task automatic add_id3v2_buffer();
		string ids[14] = '{"TPE1", "TPE2", "TPE3", "TPE4", "TIT1", "TIT2", "TIT3",
			"TALB", "TCON", "TPE5", "TIT4", "TXXX", "TCOX", "TALX"};
		logic [7:0] body[$];
		logic [7:0] b[$];
		logic [31:0] sz;
		int k, nd, size;
		for (int fr = $urandom_range(1, 5); fr > 0; fr--) begin
			if ($urandom_range(7) == 0) body.push_back("T");
			k = $urandom_range(13);
			for (int i = 0; i < 4; i++) body.push_back(ids[k][i]);
			if (k == 8) begin
				nd = $urandom_range(1, 3);
				sz = nd + 3;
			end else if ($urandom_range(9) == 0) begin
				sz = $urandom_range(60, 70);
			end else if ($urandom_range(29) == 0) begin
				sz = {1'b1, 31'($urandom)};
			end else begin
				sz = $urandom_range(0, 10);
			end
			for (int i = 3; i >= 0; i--) body.push_back(sz[8 * i +: 8]);
			body.push_back(8'($urandom)); body.push_back(8'($urandom));
			body.push_back(8'($urandom_range(3)));
			if (k == 8) begin
				body.push_back("(");
				for (int i = 0; i < nd; i++) body.push_back(8'($urandom_range(48, 57)));
				body.push_back(")");
			end else if (!sz[31] && sz > 1) begin
				for (int i = 0; i < ((sz - 1 > 63) ? 63 : sz - 1); i++)
					body.push_back(8'($urandom));
			end
		end
		b = '{"I", "D", "3", 8'($urandom_range(2, 4)), 8'h00, 8'h00};
		if ($urandom_range(9) == 0) b[$urandom_range(2)] = 8'($urandom);
		if ($urandom_range(7) == 0) b[3] = 8'($urandom);
		size = body.size() + 10 - $urandom_range(0, 3);
		for (int i = 3; i >= 0; i--) b.push_back({1'b0, 7'(size >> (7 * i))});
		if ($urandom_range(7) == 0)
			for (int i = 6; i < 10; i++) b[i] = 8'($urandom);
		foreach (body[i]) b.push_back(body[i]);
		for (int i = $urandom_range(0, 3); i > 0; i--) b.push_back(8'($urandom));
		queue_buffer(KIND_HEAD, b);
	endtask

	task automatic add_trailer_buffer();
		logic [7:0] b[$];
		int p;
		for (int i = 0; i < TrailerBytes + $urandom_range(0, 2); i++) b.push_back(8'($urandom));
		p = $urandom_range(2);
		b[p] = "T"; b[p + 1] = "A"; b[p + 2] = "G";
		if ($urandom_range(5) == 0) b[p + $urandom_range(2)] = 8'($urandom);
		queue_buffer(KIND_TRAILER, b);
	endtask

	// loose words: random flags, kinds and bytes
	task automatic add_noise();
		in_word_t w;
		for (int i = $urandom_range(1, 16); i > 0; i--) begin
			w.kind = 1'($urandom);
			w.first = $urandom_range(3) == 0;
			w.last = $urandom_range(3) == 0;
			w.data = 8'($urandom);
			pending_words.push_back(w);
		end
	endtask

	initial begin
		in_word_t w;
		logic [7:0] b[$];
		int pick;
		n_err = 0; n_words = 0; n_results = 0; n_buffers = 0;
		idle_phase = 0; quiet_cycles = 0; word_taken = 1'b0;
		in_valid = 1'b0; out_ready = 1'b0; in_data = '0;
		clear_buffer();
		gnum = '0; bkind = KIND_HEAD;
		arst_n = 1'b0;

		// words before any first mark parse as a head buffer
		w = '{kind: KIND_TRAILER, first: 1'b0, last: 1'b0, data: "I"};
		pending_words.push_back(w);
		w.data = "D"; pending_words.push_back(w);
		w.data = 8'hFF; w.last = 1'b1; pending_words.push_back(w);
		// v2 tag with a bracketed genre number
		b = '{"I", "D", "3", 8'h04, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h00, 8'h19,
			"T", "C", "O", "N", 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
			"(", "1", "7", ")"};
		queue_buffer(KIND_HEAD, b);

		while (pending_words.size() < 700) begin
			pick = $urandom_range(99);
			if (pick < 60) add_id3v2_buffer();
			else if (pick < 72) add_trailer_buffer();
			else add_noise();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		pick = pending_words.size();
		wait (pending_words.size() < pick * 2 / 3);
		idle_phase = 1;
		wait (pending_words.size() < pick / 3);
		idle_phase = 2;
		wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (10) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d result words never arrived", expected_results.size());
			n_err++;
		end
		$display("covered %0d input words in %0d buffers, %0d result words checked",
			n_words, n_buffers, n_results);
		$display("v2 frames, v1 trailers and loose words under three stall patterns");
		if (n_err == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
